FILE: rtl/core/sdop_pkg.sv
// Shared types, codes and constants of the SDO response parser.
`default_nettype none

package sdop_pkg;

    localparam int unsigned CFG_W = 16;
    localparam int unsigned HEAD_DEPTH = 10;
    localparam int unsigned DELAY_DEPTH = 7;
    localparam int unsigned EXP_BASE = 6;
    localparam int unsigned TDATA_W = 80;

    localparam logic [15:0] SVC_SDO_RES = 16'h0003;
    localparam logic [7:0] CMD_UP_INIT = 8'h40;
    localparam logic [7:0] CMD_DN_INIT = 8'h60;
    localparam logic [7:0] CMD_DN_SEG = 8'h20;
    localparam logic [7:0] CMD_UP_SEG = 8'h00;
    localparam logic [7:0] CMD_ABORT = 8'h80;
    localparam logic [7:0] CMD_MASK = 8'hE0;
    localparam logic [2:0] UNUSED_MASK = 3'h7;

    typedef enum logic [1:0] {
        KIND_UP_INIT = 2'd0,
        KIND_UP_SEG  = 2'd1,
        KIND_DN_INIT = 2'd2,
        KIND_DN_SEG  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_KIND     = 2'd0,
        REG_INDEX    = 2'd1,
        REG_SUBINDEX = 2'd2,
        REG_TOGGLE   = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_SHORT      = 3'd1,
        ST_BAD_SVC    = 3'd2,
        ST_ADDR       = 3'd3,
        ST_ABORT      = 3'd4,
        ST_BAD_CMD    = 3'd5,
        ST_BAD_UNUSED = 3'd6,
        ST_TOGGLE     = 3'd7
    } status_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] index;
        logic [7:0]  subindex;
        logic        toggle;
    } cfg_t;

    typedef struct packed {
        logic        is_data;
        logic [7:0]  data_byte;
        status_t     status;
        logic [31:0] abort_code;
        logic [31:0] complete_size;
        logic        expedited;
        logic        size_indicated;
        logic        toggle_seen;
        logic        last_segment;
        logic        end_of_response;
    } res_t;

    typedef struct packed {
        logic accept;
        logic eval;
        logic flush_emit;
        logic status_emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic flush_empty;
    } dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/sdop_cfg.sv
// Configuration registers of the SDO response parser.
`default_nettype none

module sdop_cfg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [1:0]                   cfg_index,
    input  wire logic [sdop_pkg::CFG_W-1:0]   cfg_wdata,
    output sdop_pkg::cfg_t                    cfg
);
    import sdop_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_KIND:     cfg_next.kind = kind_t'(cfg_wdata[1:0]);
                REG_INDEX:    cfg_next.index = cfg_wdata[15:0];
                REG_SUBINDEX: cfg_next.subindex = cfg_wdata[7:0];
                REG_TOGGLE:   cfg_next.toggle = cfg_wdata[0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/core/sdop_ctrl.sv
// Controller state machine of the SDO response parser.
`default_nettype none

module sdop_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    input  wire logic          s_tlast,
    output logic               s_tready,
    input  wire sdop_pkg::dp_sts_t sts,
    output sdop_pkg::ctrl_cmd_t cmd
);
    import sdop_pkg::*;

    typedef enum logic [3:0] {
        S_ACCEPT = 4'b0001,
        S_EVAL   = 4'b0010,
        S_FLUSH  = 4'b0100,
        S_STATUS = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_ACCEPT:
            begin
                s_tready = sts.out_free;
                cmd.accept = s_tvalid && sts.out_free;
                if (cmd.accept && s_tlast)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                state_next = S_FLUSH;
            end
            S_FLUSH:
            begin
                if (sts.flush_empty)
                begin
                    state_next = S_STATUS;
                end
                else
                begin
                    cmd.flush_emit = sts.out_free;
                end
            end
            S_STATUS:
            begin
                if (sts.out_free)
                begin
                    cmd.status_emit = 1'b1;
                    state_next = S_ACCEPT;
                end
            end
            default:
            begin
                state_next = S_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ACCEPT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sdop_datapath.sv
// Datapath of the SDO response parser: header store, delay line, checks, result register.
`default_nettype none

module sdop_datapath (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire sdop_pkg::cfg_t      cfg,
    input  wire sdop_pkg::ctrl_cmd_t cmd,
    input  wire logic [7:0]     payload_byte,
    input  wire logic           final_byte,
    input  wire logic           m_tready,
    output sdop_pkg::dp_sts_t   sts,
    output sdop_pkg::res_t      out,
    output logic                out_valid
);
    import sdop_pkg::*;

    logic [3:0]  pos_reg;
    logic [3:0]  pos_next;
    logic [7:0]  head_reg [HEAD_DEPTH];
    logic [7:0]  line_reg [DELAY_DEPTH];
    logic [7:0]  line_next [DELAY_DEPTH];
    logic [2:0]  fill_reg;
    logic [2:0]  fill_next;
    res_t        out_reg;
    res_t        out_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    res_t        stat_reg;
    logic [2:0]  flush_left_reg;
    logic        flush_head_reg;
    logic [1:0]  flush_idx_reg;

    logic [7:0]  cmd_byte;
    logic        svc_raw;
    logic        stream;
    logic        shift_in;
    logic [2:0]  wr_idx;
    logic [7:0]  flush_byte;
    logic [3:0]  exp_addr;

    logic        svc_ok;
    logic        addr_ok;
    logic [31:0] head32_6;
    logic [31:0] abort_seg;
    logic [2:0]  used;
    logic [2:0]  unused;
    logic [7:0]  want;
    res_t        ev;
    logic [2:0]  ev_count;
    logic        ev_head;

    assign cmd_byte = head_reg[2];
    assign svc_raw = ({head_reg[1], head_reg[0]} == SVC_SDO_RES);

    // Upload segment data goes into the delay line once service and command have passed.
    assign stream = cmd.accept && (cfg.kind == KIND_UP_SEG) && (pos_reg >= 4'd3) && svc_raw
                    && ((cmd_byte & CMD_MASK) == CMD_UP_SEG);
    assign shift_in = (!final_byte && (fill_reg >= 3'(DELAY_DEPTH - 1)))
                      || (fill_reg >= 3'(DELAY_DEPTH));
    assign wr_idx = shift_in ? (final_byte ? 3'(DELAY_DEPTH - 1) : 3'(DELAY_DEPTH - 2))
                             : fill_reg;

    assign exp_addr = 4'(EXP_BASE) + {2'b00, flush_idx_reg};
    assign flush_byte = flush_head_reg ? head_reg[exp_addr] : line_reg[0];

    always_comb
    begin
        line_next = line_reg;
        if (stream)
        begin
            if (shift_in)
            begin
                for (int i = 0; i < DELAY_DEPTH - 1; i++)
                begin
                    line_next[i] = line_reg[i + 1];
                end
            end
            line_next[wr_idx] = payload_byte;
        end
        else if (cmd.flush_emit && !flush_head_reg)
        begin
            for (int i = 0; i < DELAY_DEPTH - 1; i++)
            begin
                line_next[i] = line_reg[i + 1];
            end
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (cmd.status_emit)
        begin
            pos_next = 4'd0;
        end
        else if (cmd.accept && (pos_reg < 4'(HEAD_DEPTH)))
        begin
            pos_next = pos_reg + 4'd1;
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.status_emit)
        begin
            fill_next = 3'd0;
        end
        else if (stream)
        begin
            fill_next = wr_idx + 3'd1;
        end
    end

    // Response checks, evaluated once the final byte is stored.
    assign svc_ok = (pos_reg >= 4'd3) && svc_raw;
    assign addr_ok = (pos_reg >= 4'd6) && ({head_reg[4], head_reg[3]} == cfg.index)
                     && (head_reg[5] == cfg.subindex);
    assign head32_6 = {head_reg[9], head_reg[8], head_reg[7], head_reg[6]};
    assign abort_seg = (pos_reg >= 4'd7)
                       ? {head_reg[6], head_reg[5], head_reg[4], head_reg[3]} : 32'd0;
    assign used = 3'd4 - {1'b0, cmd_byte[3:2]};
    assign unused = cmd_byte[3:1] & UNUSED_MASK;
    assign want = (cfg.kind == KIND_UP_SEG) ? CMD_UP_SEG : CMD_DN_SEG;

    always_comb
    begin
        ev = '0;
        ev.end_of_response = 1'b1;
        ev.status = ST_OK;
        ev_count = 3'd0;
        ev_head = 1'b0;
        unique case (cfg.kind) inside
            KIND_UP_INIT:
            begin
                if (pos_reg < 4'(HEAD_DEPTH))
                    ev.status = ST_SHORT;
                else if (!svc_ok)
                    ev.status = ST_BAD_SVC;
                else if (!addr_ok)
                    ev.status = ST_ADDR;
                else if (cmd_byte == CMD_ABORT)
                begin
                    ev.status = ST_ABORT;
                    ev.abort_code = head32_6;
                end
                else if ((cmd_byte & CMD_MASK) != CMD_UP_INIT)
                    ev.status = ST_BAD_CMD;
                else
                begin
                    ev.expedited = cmd_byte[1];
                    ev.size_indicated = cmd_byte[0];
                    if (cmd_byte[1])
                    begin
                        ev_count = used;
                        ev_head = 1'b1;
                        ev.complete_size = 32'(used);
                    end
                    else if (cmd_byte[0])
                    begin
                        ev.complete_size = head32_6;
                    end
                end
            end
            KIND_DN_INIT:
            begin
                if (pos_reg < 4'd6)
                    ev.status = ST_SHORT;
                else if (!svc_ok)
                    ev.status = ST_BAD_SVC;
                else if (cmd_byte == CMD_ABORT)
                begin
                    ev.status = ST_ABORT;
                    ev.abort_code = abort_seg;
                end
                else if (cmd_byte != CMD_DN_INIT)
                    ev.status = ST_BAD_CMD;
                else if (!addr_ok)
                    ev.status = ST_ADDR;
            end
            KIND_UP_SEG, KIND_DN_SEG:
            begin
                if (pos_reg < 4'd3)
                    ev.status = ST_SHORT;
                else if (!svc_ok)
                    ev.status = ST_BAD_SVC;
                else if (cmd_byte == CMD_ABORT)
                begin
                    ev.status = ST_ABORT;
                    ev.abort_code = abort_seg;
                end
                else if ((cmd_byte & CMD_MASK) != want)
                    ev.status = ST_BAD_CMD;
                else
                begin
                    ev.toggle_seen = cmd_byte[4];
                    if (cfg.kind == KIND_UP_SEG)
                    begin
                        ev.last_segment = cmd_byte[0];
                        if (unused > fill_reg)
                            ev.status = ST_BAD_UNUSED;
                        else
                            ev_count = fill_reg - unused;
                    end
                    else if (cmd_byte[4] != cfg.toggle)
                    begin
                        ev.status = ST_TOGGLE;
                    end
                end
            end
            default:
            begin
                ev.status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        out_next = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (stream && shift_in)
        begin
            out_next = '0;
            out_next.is_data = 1'b1;
            out_next.data_byte = line_reg[0];
            out_valid_next = 1'b1;
        end
        else if (cmd.flush_emit)
        begin
            out_next = '0;
            out_next.is_data = 1'b1;
            out_next.data_byte = flush_byte;
            out_valid_next = 1'b1;
        end
        else if (cmd.status_emit)
        begin
            out_next = stat_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && (pos_reg < 4'(HEAD_DEPTH)))
        begin
            head_reg[pos_reg] <= payload_byte;
        end
        line_reg <= line_next;
        out_reg <= out_next;
        if (cmd.eval)
        begin
            stat_reg <= ev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 4'd0;
            fill_reg <= 3'd0;
            out_valid_reg <= 1'b0;
            flush_left_reg <= 3'd0;
            flush_head_reg <= 1'b0;
            flush_idx_reg <= 2'd0;
        end
        else
        begin
            pos_reg <= pos_next;
            fill_reg <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cmd.eval)
            begin
                flush_left_reg <= ev_count;
                flush_head_reg <= ev_head;
                flush_idx_reg <= 2'd0;
            end
            else if (cmd.flush_emit)
            begin
                flush_left_reg <= flush_left_reg - 3'd1;
                flush_idx_reg <= flush_idx_reg + 2'd1;
            end
        end
    end

    assign sts.out_free = !out_valid_reg || m_tready;
    assign sts.flush_empty = (flush_left_reg == 3'd0);
    assign out = out_reg;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/core/sdo_response_parser.sv
// SDO response parser top level. Payload bytes are taken one per cycle while the result
// register is empty or draining; a segment byte that pushes data out of the seven-byte delay
// line uses the same cycle. After the beat marked last, the controller evaluates the checks,
// emits the trailing data results (up to seven), leaves the flush state and emits the status
// result before the next payload beat is taken; each result also waits for m_tready. Each
// response closes with one status beat carrying tlast; data beats carry tuser high.
`default_nettype none

module sdo_response_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] payload_byte
    input  wire logic        s_tlast,   // final_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] data_byte, [10:8] status, [42:11] abort_code, [74:43] complete_size,
    // [75] expedited, [76] size_indicated, [77] toggle_seen, [78] last_segment, [79] zero
    output logic [79:0]      m_tdata,
    output logic             m_tuser,   // is_data
    output logic             m_tlast    // end_of_response
);
    import sdop_pkg::*;

    cfg_t      cfg;
    ctrl_cmd_t cmd;
    dp_sts_t   sts;
    res_t      res;
    logic      res_valid;

    sdop_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    sdop_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sdop_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .payload_byte (s_tdata),
        .final_byte   (s_tlast),
        .m_tready     (m_tready),
        .sts          (sts),
        .out          (res),
        .out_valid    (res_valid)
    );

    assign m_tvalid = res_valid;
    assign m_tuser = res.is_data;
    assign m_tlast = res.end_of_response;
    assign m_tdata = {1'b0, res.last_segment, res.toggle_seen, res.size_indicated,
                      res.expedited, res.complete_size, res.abort_code, res.status,
                      res.data_byte};

    a_status_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.status_emit |=> (m_tvalid && m_tlast))
        else $error("status beat not presented after status load");

    a_kind_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser != m_tlast))
        else $error("result beat is neither exactly data nor exactly status");

    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[79:8] == '0))
        else $error("data beat carries non-zero status fields");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (!m_tvalid || m_tready))
        else $error("input taken while result register is blocked");

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the SDO response parser: byte stream in, parsed results out.
`timescale 1ns / 1ps

module testbench;

    import sdop_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       is_final;
    } payload_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    reg_idx_t    cfg_index = REG_KIND;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;      // [7:0] payload_byte
    logic        s_tlast = 1'b0;    // final_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [7:0] data_byte, [10:8] status, [42:11] abort_code, [74:43] complete_size,
    // [75] expedited, [76] size_indicated, [77] toggle_seen, [78] last_segment
    logic [79:0] m_tdata;
    logic        m_tuser;           // is_data
    logic        m_tlast;           // end_of_response

    sdo_response_parser u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Shadow of the block's registers and parsing state.
    kind_t       cfg_kind = KIND_UP_INIT;
    logic [15:0] cfg_obj_index = '0;
    logic [7:0]  cfg_obj_sub = '0;
    logic        cfg_toggle = 1'b0;
    int unsigned rx_count = 0;
    logic [7:0]  head_buf [HEAD_DEPTH];
    logic [7:0]  seg_hold [DELAY_DEPTH];
    int unsigned seg_fill = 0;

    res_t          sdo_results_due [$];
    payload_beat_t payload_queue [$];
    logic [7:0]    frame [$];

    int unsigned beats_queued = 0;
    int unsigned beats_sent = 0;
    int unsigned mismatches = 0;
    int unsigned random_beats = 0;
    int unsigned src_gap = 0;
    int unsigned sink_stall = 0;
    logic        idling_on = 1'b1;
    logic        in_fire = 1'b0;

    task automatic queue_data_result(input logic [7:0] b);
        res_t r;
        r = '0;
        r.is_data = 1'b1;
        r.data_byte = b;
        sdo_results_due.insert(sdo_results_due.size(), r);
    endtask

    task automatic shift_seg_hold();
        for (int i = 0; i < DELAY_DEPTH - 1; i++)
            seg_hold[i] = seg_hold[i + 1];
    endtask

    // Works out the results that one accepted payload byte causes.
    task automatic sdo_parse_byte(input logic [7:0] pb, input logic is_final);
        int unsigned pos;
        int unsigned cnt;
        int unsigned used;
        int unsigned unused;
        logic [7:0]  cmd;
        logic        svc_ok;
        logic        addr_ok;
        logic [7:0]  want_cmd;
        res_t        r;
        pos = rx_count;
        if (pos < HEAD_DEPTH)
        begin
            head_buf[pos] = pb;
            rx_count = pos + 1;
        end
        else
            rx_count = HEAD_DEPTH;
        cnt = rx_count;
        svc_ok = cnt >= 3 && {head_buf[1], head_buf[0]} == SVC_SDO_RES;
        cmd = cnt >= 3 ? head_buf[2] : 8'h00;

        if (cfg_kind == KIND_UP_SEG && pos >= 3 && svc_ok && (cmd & CMD_MASK) == CMD_UP_SEG)
        begin
            // The oldest byte leaves once all but the last slot are full; only a final byte may take the last slot.
            if (!is_final && seg_fill >= DELAY_DEPTH - 1)
            begin
                queue_data_result(seg_hold[0]);
                shift_seg_hold();
                seg_fill = DELAY_DEPTH - 2;
            end
            else if (seg_fill >= DELAY_DEPTH)
            begin
                queue_data_result(seg_hold[0]);
                shift_seg_hold();
                seg_fill = DELAY_DEPTH - 1;
            end
            seg_hold[seg_fill] = pb;
            seg_fill++;
        end

        if (!is_final)
            return;

        r = '0;
        r.status = ST_OK;
        r.end_of_response = 1'b1;
        addr_ok = cnt >= 6 && {head_buf[4], head_buf[3]} == cfg_obj_index
                  && head_buf[5] == cfg_obj_sub;

        case (cfg_kind)
            KIND_UP_INIT:
            begin
                if (cnt < HEAD_DEPTH)
                    r.status = ST_SHORT;
                else if (!svc_ok)
                    r.status = ST_BAD_SVC;
                else if (!addr_ok)
                    r.status = ST_ADDR;
                else if (cmd == CMD_ABORT)
                begin
                    r.status = ST_ABORT;
                    r.abort_code = {head_buf[9], head_buf[8], head_buf[7], head_buf[6]};
                end
                else if ((cmd & CMD_MASK) != CMD_UP_INIT)
                    r.status = ST_BAD_CMD;
                else
                begin
                    r.expedited = cmd[1];
                    r.size_indicated = cmd[0];
                    if (cmd[1])
                    begin
                        used = 4 - cmd[3:2];
                        for (int i = 0; i < used; i++)
                            queue_data_result(head_buf[EXP_BASE + i]);
                        r.complete_size = used;
                    end
                    else if (cmd[0])
                        r.complete_size = {head_buf[9], head_buf[8], head_buf[7], head_buf[6]};
                end
            end
            KIND_DN_INIT:
            begin
                if (cnt < 6)
                    r.status = ST_SHORT;
                else if (!svc_ok)
                    r.status = ST_BAD_SVC;
                else if (cmd == CMD_ABORT)
                begin
                    r.status = ST_ABORT;
                    if (cnt >= 7)
                        r.abort_code = {head_buf[6], head_buf[5], head_buf[4], head_buf[3]};
                end
                else if (cmd != CMD_DN_INIT)
                    r.status = ST_BAD_CMD;
                else if (!addr_ok)
                    r.status = ST_ADDR;
            end
            default:
            begin
                want_cmd = cfg_kind == KIND_UP_SEG ? CMD_UP_SEG : CMD_DN_SEG;
                if (cnt < 3)
                    r.status = ST_SHORT;
                else if (!svc_ok)
                    r.status = ST_BAD_SVC;
                else if (cmd == CMD_ABORT)
                begin
                    r.status = ST_ABORT;
                    if (cnt >= 7)
                        r.abort_code = {head_buf[6], head_buf[5], head_buf[4], head_buf[3]};
                end
                else if ((cmd & CMD_MASK) != want_cmd)
                    r.status = ST_BAD_CMD;
                else
                begin
                    r.toggle_seen = cmd[4];
                    if (cfg_kind == KIND_UP_SEG)
                    begin
                        unused = cmd[3:1] & UNUSED_MASK;
                        r.last_segment = cmd[0];
                        if (unused > seg_fill)
                            r.status = ST_BAD_UNUSED;
                        else
                            for (int i = 0; i < seg_fill - unused; i++)
                                queue_data_result(seg_hold[i]);
                    end
                    else if (cmd[4] != cfg_toggle)
                        r.status = ST_TOGGLE;
                end
            end
        endcase

        sdo_results_due.insert(sdo_results_due.size(), r);
        rx_count = 0;
        seg_fill = 0;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    // Monitor: checks result beats, then records and predicts accepted payload beats.
    always @(posedge clk)
    begin : monitor
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (sdo_results_due.size() == 0)
            begin
                $error("result beat with no result expected: tdata 0x%0h", m_tdata);
                mismatches++;
            end
            else
            begin
                want = sdo_results_due.pop_front();
                check_field("is_data", want.is_data, m_tuser);
                check_field("data_byte", want.data_byte, m_tdata[7:0]);
                check_field("status", want.status, m_tdata[10:8]);
                check_field("abort_code", want.abort_code, m_tdata[42:11]);
                check_field("complete_size", want.complete_size, m_tdata[74:43]);
                check_field("expedited", want.expedited, m_tdata[75]);
                check_field("size_indicated", want.size_indicated, m_tdata[76]);
                check_field("toggle_seen", want.toggle_seen, m_tdata[77]);
                check_field("last_segment", want.last_segment, m_tdata[78]);
                check_field("end_of_response", want.end_of_response, m_tlast);
            end
        end
        in_fire <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            beats_sent++;
            sdo_parse_byte(s_tdata, s_tlast);
        end
    end

    // Driver: feeds payload beats and sets the result-side ready, both with random bursts of idling.
    always @(negedge clk)
    begin : driver
        payload_beat_t nb;
        if (rst_n)
        begin
            if (!s_tvalid || in_fire)
            begin
                if (idling_on && src_gap > 0)
                begin
                    src_gap <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (payload_queue.size() == 0)
                    s_tvalid <= 1'b0;
                else if (idling_on && $urandom_range(0, 7) == 0)
                begin
                    src_gap <= $urandom_range(0, 14);
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    nb = payload_queue.pop_front();
                    s_tdata <= nb.data;
                    s_tlast <= nb.is_final;
                    s_tvalid <= 1'b1;
                end
            end
            if (idling_on && sink_stall > 0)
            begin
                sink_stall <= sink_stall - 1;
                m_tready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                sink_stall <= $urandom_range(0, 14);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic queue_frame();
        payload_beat_t b;
        for (int i = 0; i < frame.size(); i++)
        begin
            b.data = frame[i];
            b.is_final = (i == frame.size() - 1);
            payload_queue.insert(payload_queue.size(), b);
            beats_queued++;
        end
    endtask

    // Called at a falling edge while the block is idle; the shadow follows at once.
    task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_KIND:     cfg_kind = kind_t'(val[1:0]);
            REG_INDEX:    cfg_obj_index = val;
            REG_SUBINDEX: cfg_obj_sub = val[7:0];
            REG_TOGGLE:   cfg_toggle = val[0];
        endcase
        @(negedge clk);
    endtask

    task automatic set_config(input kind_t kind, input logic [15:0] idx,
                              input logic [7:0] sub, input logic tog);
        write_reg(REG_KIND, 16'(kind));
        write_reg(REG_INDEX, idx);
        write_reg(REG_SUBINDEX, {8'h00, sub});
        write_reg(REG_TOGGLE, {15'h0000, tog});
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Waits until every byte is in and every result out, then lets the block settle.
    task automatic wait_drained();
        while (beats_sent != beats_queued || sdo_results_due.size() != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic push_random_bytes(input int unsigned n);
        for (int i = 0; i < n; i++)
            frame.insert(frame.size(), 8'($urandom_range(0, 255)));
    endtask

    // Builds one response for the current kind: mostly well formed, some of it broken.
    task automatic build_response();
        int unsigned sel;
        int unsigned ndata;
        int unsigned unused;
        int unsigned cut;
        logic [7:0]  cmd;
        logic [7:0]  addr [3];
        logic        tog;
        frame.delete();
        addr[0] = cfg_obj_index[7:0];
        addr[1] = cfg_obj_index[15:8];
        addr[2] = cfg_obj_sub;
        if ($urandom_range(0, 9) == 0)
            addr[$urandom_range(0, 2)] ^= 8'(1 << $urandom_range(0, 7));
        ndata = 0;

        case (cfg_kind)
            KIND_UP_INIT: cmd = CMD_UP_INIT | 8'($urandom_range(0, 31));
            KIND_DN_INIT: cmd = CMD_DN_INIT;
            KIND_UP_SEG:
            begin
                sel = $urandom_range(0, 9);
                ndata = sel == 0 ? 0 : (sel < 7 ? sel : $urandom_range(8, 14));
                if ($urandom_range(0, 99) < 85)
                    unused = $urandom_range(0, ndata < DELAY_DEPTH ? ndata : DELAY_DEPTH);
                else
                    unused = $urandom_range(0, 7);
                cmd = {3'b000, 1'($urandom_range(0, 1)), 3'(unused), 1'($urandom_range(0, 1))};
            end
            default:
            begin
                tog = $urandom_range(0, 99) < 85 ? cfg_toggle : !cfg_toggle;
                cmd = {3'b001, tog, 4'($urandom_range(0, 15))};
            end
        endcase
        sel = $urandom_range(0, 99);
        if (sel < 8)
            cmd = CMD_ABORT;
        else if (sel < 13)
            cmd = 8'($urandom_range(0, 255));

        if ($urandom_range(0, 19) == 0)
        begin
            frame.insert(frame.size(), 8'($urandom_range(0, 255)));
            frame.insert(frame.size(), 8'($urandom_range(0, 255)));
        end
        else
        begin
            frame.insert(frame.size(), SVC_SDO_RES[7:0]);
            frame.insert(frame.size(), SVC_SDO_RES[15:8]);
        end
        frame.insert(frame.size(), cmd);

        if (cmd == CMD_ABORT && cfg_kind != KIND_UP_INIT)
            push_random_bytes(4);
        else if (cfg_kind == KIND_UP_INIT || cfg_kind == KIND_DN_INIT)
        begin
            for (int i = 0; i < 3; i++)
                frame.insert(frame.size(), addr[i]);
            push_random_bytes(4);
        end
        else if (cfg_kind == KIND_UP_SEG)
            push_random_bytes(ndata);
        else
            push_random_bytes(7);

        sel = $urandom_range(0, 99);
        if (sel < 8 && frame.size() > 1)
        begin
            cut = $urandom_range(1, frame.size() - 1);
            while (frame.size() > cut)
                void'(frame.pop_back());
        end
        else if (sel >= 92)
            push_random_bytes($urandom_range(1, 4));
    endtask

    task automatic run_phase(input int unsigned p, input int unsigned nresp);
        logic [15:0] idx;
        logic [7:0]  sub;
        case (p % 3)
            0:       idx = 16'h0000;
            1:       idx = 16'hFFFF;
            default: idx = 16'($urandom_range(0, 65535));
        endcase
        case ((p + 1) % 3)
            0:       sub = 8'h00;
            1:       sub = 8'hFF;
            default: sub = 8'($urandom_range(0, 255));
        endcase
        set_config(kind_t'(p % 4), idx, sub, 1'((p / 4) % 2));
        for (int i = 0; i < nresp; i++)
        begin
            build_response();
            random_beats += frame.size();
            queue_frame();
        end
        wait_drained();
    endtask

    initial
    begin : stimulus
        int unsigned phase_no;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Expedited upload of four bytes with the reset configuration.
        frame = '{8'h03, 8'h00, 8'h43, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h5A, 8'hA5};
        queue_frame();
        wait_drained();

        // Eight segment bytes stream through the delay line, one of them unused at the end;
        // then an unused count larger than the data held.
        set_config(KIND_UP_SEG, 16'hFFFF, 8'hFF, 1'b1);
        frame = '{8'h03, 8'h00, 8'h03, 8'hFF, 8'h00, 8'h11, 8'h22, 8'h33, 8'h44,
                  8'h55, 8'h66};
        queue_frame();
        frame = '{8'h03, 8'h00, 8'h0E};
        queue_frame();
        wait_drained();

        // An abort too short to carry its code.
        set_config(KIND_DN_SEG, 16'h1234, 8'h56, 1'b0);
        frame = '{8'h03, 8'h00, 8'h80, 8'h12, 8'h34};
        queue_frame();
        wait_drained();

        phase_no = 0;
        while (random_beats < 160)
        begin
            run_phase(phase_no, $urandom_range(2, 5));
            phase_no++;
        end
        // Closing stretch at full rate on both sides.
        idling_on = 1'b0;
        run_phase(phase_no, 3);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
